[src/ima_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_pkg: shared types and constants of the I2C register access master
// Payload structs, operation codes, sequence lengths and the per-step action
// record that the step decoder hands to the top level.
// ----------------------------------------------------------------------------
package ima_pkg;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam int unsigned WRITE_STEPS = 88;
	localparam int unsigned READ_STEPS  = 112;

	localparam logic [6:0] DEV_ADDR_RESET = 7'd104;
	localparam logic       RW_WRITE       = 1'b0;
	localparam logic       RW_READ        = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} in_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       nack;
	} out_t;

	typedef enum logic [1:0] {
		PIN_KEEP,
		PIN_LO,
		PIN_HI,
		PIN_BIT
	} pin_op_t;

	typedef enum logic [1:0] {
		SEL_ADDR_W,
		SEL_ADDR_R,
		SEL_REG,
		SEL_DATA
	} byte_sel_t;

	typedef struct packed {
		pin_op_t   scl_op;
		pin_op_t   sda_op;
		byte_sel_t byte_sel;
		logic [2:0] bit_idx;
		logic      sample_ack;
		logic      sample_rx;
	} act_t;

endpackage

[src/ima_step_dec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_step_dec: step decoder of the I2C register access master
// Maps a step number of a write or read sequence onto the pin action of
// that step, the byte and bit to send, and the sampling strobes.
// ----------------------------------------------------------------------------
module ima_step_dec (
	input  logic [6:0]    step,
	input  logic          is_read,
	output ima_pkg::act_t act
);

	localparam ima_pkg::act_t ACT_IDLE = '{
		scl_op: ima_pkg::PIN_KEEP, sda_op: ima_pkg::PIN_KEEP,
		byte_sel: ima_pkg::SEL_ADDR_W, bit_idx: 3'd0,
		sample_ack: 1'b0, sample_rx: 1'b0};

	function automatic ima_pkg::act_t start_act(input logic [1:0] q);
		ima_pkg::act_t a;
		a = ACT_IDLE;
		unique case (q)
			2'd0: a.sda_op = ima_pkg::PIN_HI;
			2'd1: a.scl_op = ima_pkg::PIN_HI;
			2'd2: a.sda_op = ima_pkg::PIN_LO;
			default: a.scl_op = ima_pkg::PIN_LO;
		endcase
		return a;
	endfunction

	function automatic ima_pkg::act_t stop_act(input logic [1:0] q);
		ima_pkg::act_t a;
		a = ACT_IDLE;
		unique case (q)
			2'd0: a.sda_op = ima_pkg::PIN_LO;
			2'd1: a.scl_op = ima_pkg::PIN_HI;
			default: a.sda_op = ima_pkg::PIN_HI;
		endcase
		return a;
	endfunction

	// Eight bits of three steps each, then a three step ack slot.
	function automatic ima_pkg::act_t send_act(input logic [4:0] q,
			input ima_pkg::byte_sel_t sel, input logic smp);
		ima_pkg::act_t a;
		logic [2:0] b;
		logic [4:0] r;
		a = ACT_IDLE;
		b = 3'd0;
		r = q;
		for (int i = 1; i < 8; i++) begin
			if (q >= 5'(3 * i)) begin
				b = 3'(i);
				r = q - 5'(3 * i);
			end
		end
		if (q < 5'd24) begin
			priority if (r == 5'd0) begin
				a.sda_op   = ima_pkg::PIN_BIT;
				a.byte_sel = sel;
				a.bit_idx  = b;
			end else if (r == 5'd1) begin
				a.scl_op = ima_pkg::PIN_HI;
			end else begin
				a.scl_op = ima_pkg::PIN_LO;
			end
		end else if (q == 5'd24) begin
			a.sda_op = ima_pkg::PIN_HI;
		end else if (q == 5'd25) begin
			a.scl_op     = ima_pkg::PIN_HI;
			a.sample_ack = smp;
		end else begin
			a.scl_op = ima_pkg::PIN_LO;
		end
		return a;
	endfunction

	// Release SDA, then clock in the byte, each bit sampled while SCL is high.
	function automatic ima_pkg::act_t recv_act(input logic [4:0] q);
		ima_pkg::act_t a;
		logic [4:0] r;
		a = ACT_IDLE;
		r = q - 5'd1;
		if (q == 5'd0) begin
			a.sda_op = ima_pkg::PIN_HI;
		end else if (!r[0]) begin
			a.scl_op    = ima_pkg::PIN_HI;
			a.sample_rx = 1'b1;
			a.bit_idx   = r[3:1];
		end else begin
			a.scl_op = ima_pkg::PIN_LO;
		end
		return a;
	endfunction

	always_comb begin
		priority if (step < 7'd4) begin
			act = start_act(step[1:0]);
		end else if (step < 7'd31) begin
			act = send_act(5'(step - 7'd4), ima_pkg::SEL_ADDR_W, 1'b1);
		end else if (step < 7'd58) begin
			act = send_act(5'(step - 7'd31), ima_pkg::SEL_REG, 1'b1);
		end else if (!is_read) begin
			if (step < 7'd85) begin
				act = send_act(5'(step - 7'd58), ima_pkg::SEL_DATA, 1'b1);
			end else begin
				act = stop_act(2'(step - 7'd85));
			end
		end else if (step < 7'd62) begin
			act = start_act(2'(step - 7'd58));
		end else if (step < 7'd89) begin
			act = send_act(5'(step - 7'd62), ima_pkg::SEL_ADDR_R, 1'b1);
		end else if (step < 7'd106) begin
			act = recv_act(5'(step - 7'd89));
		end else if (step < 7'd109) begin
			// Master NACK: the tail of an ack slot that is not sampled.
			act = send_act(5'(7'd24 + step - 7'd106), ima_pkg::SEL_ADDR_W, 1'b0);
		end else begin
			act = stop_act(2'(step - 7'd109));
		end
	end

endmodule

[src/i2c_master_register_access.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_access: tick-driven I2C master for one-register access
// Every input transfer is one tick; every tick yields one output transfer
// with the SCL and SDA levels, status and the last byte read.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    ima_pkg::in_t  (op, reg, data, sda)
//   out       output     out_valid / out_ready  ima_pkg::out_t (pins, status, byte)
//   cfg       input      cfg_we, no wait        cfg_wdata: 7-bit device address
//
// One tick is taken per clock cycle unless the output stalls. The whole
// sequencer step (decode of the step number, pin update, ack and receive
// sampling) runs combinationally from the state registers into the result
// register, so the rate is set by that state update and the result register alone.
// A write transaction lasts 88 ticks and a read 112 ticks; idle ticks hold
// the pin levels and report busy low.
// Reset puts the sequencer in idle with both lines released and the device
// address at its default. A stalled output stops input acceptance only
// while the result register is full and not being taken.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ima_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ima_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [6:0]    cfg_wdata
);

	// Sequencer state. phase_q is zero when idle, otherwise the next step
	// number plus one.
	logic [6:0] dev_addr_q;
	logic [6:0] phase_q;
	logic       is_read_q;
	logic [7:0] reg_q;
	logic [7:0] data_q;
	logic [7:0] shift_q;
	logic [7:0] read_q;
	logic       nack_q;
	logic       scl_q;
	logic       sda_q;

	ima_pkg::out_t out_q;
	logic          out_valid_q;

	logic          in_fire;
	logic          start;
	logic          active;
	logic          is_read_e;
	logic [7:0]    reg_e;
	logic [7:0]    data_e;
	logic [7:0]    shift_e;
	logic          nack_e;
	logic [6:0]    step;
	logic [6:0]    last_step;
	logic          done;
	ima_pkg::act_t act;
	logic [7:0]    tx_byte;
	logic          tx_bit;
	logic          scl_n;
	logic          sda_n;
	logic [7:0]    shift_n;
	logic          nack_n;
	logic [7:0]    read_n;
	logic [6:0]    phase_n;

	// The result register parts the two sides: a new tick is taken whenever
	// the register is empty or its transfer completes in this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// An operation is only taken while idle; the tick that takes it already
	// performs step zero with the operands taken straight from the input.
	assign start = (phase_q == 7'd0) &&
		((in_data.operation == ima_pkg::OP_WRITE) ||
		 (in_data.operation == ima_pkg::OP_READ));
	assign active    = start || (phase_q != 7'd0);
	assign is_read_e = start ? (in_data.operation == ima_pkg::OP_READ) : is_read_q;
	assign reg_e     = start ? in_data.reg_addr : reg_q;
	assign data_e    = start ? in_data.write_data : data_q;
	assign shift_e   = start ? 8'd0 : shift_q;
	assign nack_e    = start ? 1'b0 : nack_q;

	assign last_step = is_read_e ? 7'(ima_pkg::READ_STEPS - 1) :
		7'(ima_pkg::WRITE_STEPS - 1);

	always_comb begin
		step = start ? 7'd0 : phase_q - 7'd1;
		if (step > last_step) begin
			step = last_step;
		end
	end

	ima_step_dec u_step_dec (
		.step    (step),
		.is_read (is_read_e),
		.act     (act)
	);

	// The address byte reads the live device address register.
	always_comb begin
		unique case (act.byte_sel)
			ima_pkg::SEL_ADDR_W: tx_byte = {dev_addr_q, ima_pkg::RW_WRITE};
			ima_pkg::SEL_ADDR_R: tx_byte = {dev_addr_q, ima_pkg::RW_READ};
			ima_pkg::SEL_REG:    tx_byte = reg_e;
			default:             tx_byte = data_e;
		endcase
	end

	assign tx_bit = tx_byte[3'd7 - act.bit_idx];

	always_comb begin
		scl_n = scl_q;
		sda_n = sda_q;
		if (active) begin
			unique case (act.scl_op)
				ima_pkg::PIN_LO: scl_n = 1'b0;
				ima_pkg::PIN_HI: scl_n = 1'b1;
				default:         scl_n = scl_q;
			endcase
			unique case (act.sda_op)
				ima_pkg::PIN_LO:  sda_n = 1'b0;
				ima_pkg::PIN_HI:  sda_n = 1'b1;
				ima_pkg::PIN_BIT: sda_n = tx_bit;
				default:          sda_n = sda_q;
			endcase
		end
	end

	// Acks are collected in a sticky flag; the transaction never aborts.
	always_comb begin
		nack_n  = nack_e;
		shift_n = shift_e;
		if (active && act.sample_ack && in_data.sda_in) begin
			nack_n = 1'b1;
		end
		if (active && act.sample_rx && in_data.sda_in) begin
			shift_n = shift_e | (8'h80 >> act.bit_idx);
		end
	end

	assign done    = active && (step == last_step);
	assign read_n  = (done && is_read_e) ? shift_n : read_q;
	assign phase_n = !active ? phase_q : (done ? 7'd0 : step + 7'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= ima_pkg::DEV_ADDR_RESET;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 7'd0;
			is_read_q <= 1'b0;
			reg_q     <= 8'd0;
			data_q    <= 8'd0;
			shift_q   <= 8'd0;
			read_q    <= 8'd0;
			nack_q    <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
		end else if (in_fire) begin
			phase_q   <= phase_n;
			is_read_q <= is_read_e;
			reg_q     <= reg_e;
			data_q    <= data_e;
			shift_q   <= shift_n;
			read_q    <= read_n;
			nack_q    <= nack_n;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q.scl       <= scl_n;
			out_q.sda       <= sda_n;
			out_q.busy_res  <= active;
			out_q.done_res  <= done;
			out_q.read_data <= read_n;
			out_q.nack      <= nack_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A finished transaction is always reported on a busy tick.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.done_res) |-> out_data.busy_res)
		else $error("done reported on an idle tick");

	// The step counter never runs past the read sequence.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q <= 7'(ima_pkg::READ_STEPS)) &&
		(is_read_q || (phase_q <= 7'(ima_pkg::WRITE_STEPS))))
		else $error("phase beyond the end of the sequence");

	// A write started from idle moves on to its second step.
	a_write_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (phase_q == 7'd0) && (in_data.operation == ima_pkg::OP_WRITE))
		|=> ((phase_q == 7'd2) && !is_read_q))
		else $error("write did not start");

	// Without an accepted tick the sequencer does not move.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> ($stable(phase_q) && $stable(scl_q) && $stable(sda_q)))
		else $error("sequencer moved without a tick");

endmodule
